// ===== rtl/btc_pkg.sv =====
package btc_pkg;

  localparam int ADDR_W = 5;
  localparam int DIV_STEPS = 64;
  localparam logic [20:0] RAW_FULL = 21'd1048576;
  localparam logic signed [32:0] V1_OFFSET = 33'sd128000;
  localparam logic [63:0] P_SCALE = 64'd3125;
  localparam logic [63:0] P1_BIAS = 64'h0000_8000_0000_0000;

  typedef enum logic [2:0] {
    REG_T1,
    REG_T2,
    REG_T3,
    REG_P1,
    REG_P2_P3,
    REG_P4_P5,
    REG_P6_P7,
    REG_P8_P9
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic signed [15:0] tc;
    logic signed [31:0] tf;
    logic               bad;
  } side_t;

endpackage

// ===== rtl/btc_temp.sv =====
module btc_temp import btc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  input  cal_t               cal,
  output logic               out_valid,
  output logic signed [15:0] out_tc,
  output logic signed [31:0] out_tf,
  output logic signed [32:0] out_v1,
  output logic [19:0]        out_ap
);

  logic [3:0]         vld;
  logic [31:0]        a, b, ma, mbb, x1, mq, tf3, q12, x2, tcr, tc32;
  logic [19:0]        ap1, ap2, ap3;
  logic signed [15:0] tc_sat;
  logic signed [32:0] v1;

  always_comb begin
    a = 32'(raw_temperature[19:3]) - 32'({cal.t1, 1'b0});
    b = 32'(raw_temperature[19:4]) - 32'(cal.t1);
    q12 = 32'($signed(mbb) >>> 12);
    x2 = 32'($signed(mq) >>> 14);
    tcr = tf3 * 32'd5 + 32'd128;
    tc32 = 32'($signed(tcr) >>> 8);
    if (tc32[31] && !(&tc32[30:15])) begin
      tc_sat = -16'sd32768;
    end else if (!tc32[31] && (|tc32[30:15])) begin
      tc_sat = 16'sd32767;
    end else begin
      tc_sat = $signed(tc32[15:0]);
    end
    v1 = 33'($signed(tf3)) - V1_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma <= a * 32'(cal.t2);
      mbb <= b * b;
      ap1 <= raw_pressure;
      x1 <= 32'($signed(ma) >>> 11);
      mq <= q12 * 32'(cal.t3);
      ap2 <= ap1;
      tf3 <= x1 + x2;
      ap3 <= ap2;
      out_tc <= tc_sat;
      out_tf <= $signed(tf3);
      out_v1 <= v1;
      out_ap <= ap3;
    end
  end

  assign out_valid = vld[3];

endmodule

// ===== rtl/btc_pre.sv =====
module btc_pre import btc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] in_tc,
  input  logic signed [31:0] in_tf,
  input  logic signed [32:0] in_v1,
  input  logic [19:0]        in_ap,
  input  cal_t               cal,
  output logic               out_valid,
  output side_t              out_side,
  output logic [63:0]        out_n,
  output logic signed [30:0] out_dv
);

  logic [5:0]         vld;
  side_t              sd [6];
  logic signed [65:0] vv_full;
  logic signed [48:0] v1p5_full, v1p2_full, v1p5, v1p2, v1p5_2, v1p2_2;
  logic [63:0]        vv, a6, a3, v2, v2_4, w, m, num, nsum;
  logic signed [79:0] a6_full, a3_full;
  logic signed [80:0] m_full;
  logic [19:0]        ap [4];
  logic signed [30:0] dv, dv6;

  always_comb begin
    vv_full = in_v1 * in_v1;
    v1p5_full = in_v1 * cal.p5;
    v1p2_full = in_v1 * cal.p2;
    a6_full = $signed(vv) * cal.p6;
    a3_full = $signed(vv) * cal.p3;
    m_full = $signed(w + P1_BIAS) * $signed({1'b0, cal.p1});
    nsum = num * P_SCALE;
  end

  assign dv = $signed(m[63:33]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= '{tc: in_tc, tf: in_tf, bad: 1'b0};
      sd[1] <= sd[0];
      sd[2] <= sd[1];
      sd[3] <= sd[2];
      sd[4] <= '{tc: sd[3].tc, tf: sd[3].tf, bad: (dv == '0)};
      sd[5] <= sd[4];
      vv <= vv_full[63:0];
      v1p5 <= v1p5_full;
      v1p2 <= v1p2_full;
      ap[0] <= in_ap;
      a6 <= a6_full[63:0];
      a3 <= a3_full[63:0];
      v1p5_2 <= v1p5;
      v1p2_2 <= v1p2;
      ap[1] <= ap[0];
      v2 <= a6 + (64'(v1p5_2) << 17) + (64'(cal.p4) << 35);
      w <= 64'($signed(a3) >>> 8) + (64'(v1p2_2) << 12);
      ap[2] <= ap[1];
      m <= m_full[63:0];
      v2_4 <= v2;
      ap[3] <= ap[2];
      dv6 <= dv;
      num <= (64'(RAW_FULL - 21'(ap[3])) << 31) - v2_4;
      out_dv <= dv6;
      out_n <= nsum;
    end
  end

  assign out_side = sd[5];
  assign out_valid = vld[5];

endmodule

// ===== rtl/btc_div.sv =====
module btc_div import btc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        in_n,
  input  logic signed [30:0] in_dv,
  input  side_t              in_side,
  output logic               out_valid,
  output logic [63:0]        out_p,
  output side_t              out_side
);

  typedef struct packed {
    logic [63:0] dq;
    logic [30:0] rem;
    logic [30:0] ad;
    logic        neg;
    side_t       side;
  } div_stage_t;

  logic [DIV_STEPS+1:0] vld;
  div_stage_t           st [DIV_STEPS+1];
  logic [63:0]          an;
  logic [30:0]          ad;

  assign an = in_n[63] ? (64'd0 - in_n) : in_n;
  assign ad = in_dv[30] ? (31'd0 - 31'(in_dv)) : 31'(in_dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= '{dq: an, rem: '0, ad: ad, neg: in_n[63] ^ in_dv[30], side: in_side};
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [31:0] sh, diff;
    logic        ge;
    assign sh = {st[i].rem, st[i].dq[63]};
    assign diff = sh - {1'b0, st[i].ad};
    assign ge = (sh >= {1'b0, st[i].ad});
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= '{dq: {st[i].dq[62:0], ge}, rem: (ge ? diff[30:0] : sh[30:0]),
                     ad: st[i].ad, neg: st[i].neg, side: st[i].side};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p <= st[DIV_STEPS].neg ? (64'd0 - st[DIV_STEPS].dq) : st[DIV_STEPS].dq;
      out_side <= st[DIV_STEPS].side;
    end
  end

  assign out_valid = vld[DIV_STEPS+1];

endmodule

// ===== rtl/btc_post.sv =====
module btc_post import btc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        in_p,
  input  side_t              in_side,
  input  cal_t               cal,
  output logic               out_valid,
  output logic signed [15:0] out_tc,
  output logic signed [31:0] out_tf,
  output logic [31:0]        out_press,
  output logic               out_bad
);

  logic [3:0]         vld;
  side_t              sd [3];
  logic [63:0]        p2, p3, p4, x, p13x, v2b, v2b3, v2b4, pp0, y, v1c, sum, s;
  logic [31:0]        pp1, pp2;
  logic signed [66:0] x_full;
  logic signed [79:0] v2_full;
  logic [31:0]        press;

  always_comb begin
    x_full = cal.p9 * $signed(in_p[63:13]);
    v2_full = $signed(in_p) * cal.p8;
    y = pp0 + {pp1 + pp2, 32'd0};
    sum = p4 + v1c + v2b4;
    s = 64'($signed(sum) >>> 8) + (64'(cal.p7) << 4);
    if (sd[2].bad || s[63]) begin
      press = '0;
    end else if (|s[62:32]) begin
      press = '1;
    end else begin
      press = s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= x_full[63:0];
      p13x <= 64'($signed(in_p[63:13]));
      v2b <= 64'($signed(v2_full[63:0]) >>> 19);
      p2 <= in_p;
      sd[0] <= in_side;
      pp0 <= x[31:0] * p13x[31:0];
      pp1 <= x[31:0] * p13x[63:32];
      pp2 <= x[63:32] * p13x[31:0];
      v2b3 <= v2b;
      p3 <= p2;
      sd[1] <= sd[0];
      v1c <= 64'($signed(y) >>> 25);
      v2b4 <= v2b3;
      p4 <= p3;
      sd[2] <= sd[1];
      out_tc <= sd[2].tc;
      out_tf <= sd[2].tf;
      out_press <= press;
      out_bad <= sd[2].bad;
    end
  end

  assign out_valid = vld[3];

endmodule

// ===== rtl/baro_temp_compensation_core.sv =====
// datapath: an input transfer passes through btc_temp, btc_pre, btc_div and btc_post to its result on the master side
// throughput: one item per cycle, set by the 64-step pipelined divider and the
// other stages that each advance together whenever the output register is free
// reset: rst is synchronous; it clears all stage valid bits and the calibration
// registers to zero
module baro_temp_compensation_core import btc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,  // raw_temperature, raw_pressure
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [79:0]       m_tdata,  // temperature_centi, fine_temperature, pressure_q24_8
  output logic              m_tuser   // pressure_invalid
);

  logic [15:0] t1, t2, t3, p1;
  logic [31:0] p23, p45, p67, p89;
  cal_t        cal;
  logic        en;

  logic               tv, pv, dv_valid;
  logic signed [15:0] t_tc;
  logic signed [31:0] t_tf;
  logic signed [32:0] t_v1;
  logic [19:0]        t_ap;
  side_t              p_side, d_side;
  logic [63:0]        p_n, d_p;
  logic signed [30:0] p_dv;
  logic signed [15:0] o_tc;
  logic signed [31:0] o_tf;
  logic [31:0]        o_press;

  assign pready = 1'b1;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      p1 <= '0;
      p23 <= '0;
      p45 <= '0;
      p67 <= '0;
      p89 <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_T1: t1 <= pwdata[15:0];
        REG_T2: t2 <= pwdata[15:0];
        REG_T3: t3 <= pwdata[15:0];
        REG_P1: p1 <= pwdata[15:0];
        REG_P2_P3: p23 <= pwdata;
        REG_P4_P5: p45 <= pwdata;
        REG_P6_P7: p67 <= pwdata;
        REG_P8_P9: p89 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_T1: prdata = 32'(t1);
      REG_T2: prdata = 32'(t2);
      REG_T3: prdata = 32'(t3);
      REG_P1: prdata = 32'(p1);
      REG_P2_P3: prdata = p23;
      REG_P4_P5: prdata = p45;
      REG_P6_P7: prdata = p67;
      REG_P8_P9: prdata = p89;
      default: prdata = '0;
    endcase
  end

  always_comb begin
    cal.t1 = t1;
    cal.t2 = $signed(t2);
    cal.t3 = $signed(t3);
    cal.p1 = p1;
    cal.p2 = $signed(p23[31:16]);
    cal.p3 = $signed(p23[15:0]);
    cal.p4 = $signed(p45[31:16]);
    cal.p5 = $signed(p45[15:0]);
    cal.p6 = $signed(p67[31:16]);
    cal.p7 = $signed(p67[15:0]);
    cal.p8 = $signed(p89[31:16]);
    cal.p9 = $signed(p89[15:0]);
  end

  btc_temp u_temp (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid && s_tready),
    .raw_temperature(s_tdata[19:0]), .raw_pressure(s_tdata[39:20]), .cal(cal),
    .out_valid(tv), .out_tc(t_tc), .out_tf(t_tf), .out_v1(t_v1), .out_ap(t_ap)
  );

  btc_pre u_pre (
    .clk(clk), .rst(rst), .en(en), .in_valid(tv), .in_tc(t_tc), .in_tf(t_tf),
    .in_v1(t_v1), .in_ap(t_ap), .cal(cal),
    .out_valid(pv), .out_side(p_side), .out_n(p_n), .out_dv(p_dv)
  );

  btc_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(pv), .in_n(p_n), .in_dv(p_dv),
    .in_side(p_side), .out_valid(dv_valid), .out_p(d_p), .out_side(d_side)
  );

  btc_post u_post (
    .clk(clk), .rst(rst), .en(en), .in_valid(dv_valid), .in_p(d_p), .in_side(d_side),
    .cal(cal), .out_valid(m_tvalid), .out_tc(o_tc), .out_tf(o_tf),
    .out_press(o_press), .out_bad(m_tuser)
  );

  assign m_tdata = {o_press, o_tf, o_tc};

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[79:48] == 32'd0)
    else $error("invalid pressure result not zero");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
